// ===== rtl/core/scca_pkg.sv =====
package scca_pkg;

    localparam int NUM_CLASSES = 9;
    localparam int PAGE_SHIFT  = 12;
    localparam int MIN_SHIFT   = 4;
    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 32;
    localparam int CLASS_W     = 4;
    localparam int STAT_W      = 2;
    localparam int CFG_W       = 5;
    localparam int LIMIT_RESET = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_PAGE_CHUNKS = 256;

    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr REGION_TOP = 48'h0016_8000_1000;
    localparam t_addr REGION_BASE [NUM_CLASSES] = '{
        48'h0000_0100_0000, 48'h0002_8000_1000, 48'h0005_0000_1000,
        48'h0007_8000_1000, 48'h000A_0000_1000, 48'h000C_8000_1000,
        48'h000F_0000_1000, 48'h0011_8000_1000, 48'h0014_0000_1000
    };

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNMANAGED = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_PAGES  = 2'd3;

    typedef struct packed {
        logic load;
        logic decode;
        logic execute;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic pop;
    } t_stat;

endpackage

// ===== rtl/core/scca_ram.sv =====
module scca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/scca_ctrl.sv =====
module scca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  scca_pkg::t_stat i_stat,
    output scca_pkg::t_ctrl o_ctrl,
    output logic            busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_EXE  = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DEC;
            end
            S_DEC: n_state = S_EXE;
            S_EXE: begin
                n_state = i_stat.pop ? S_POP : S_IDLE;
            end
            S_POP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_ctrl.load    = start && (r_state == S_IDLE);
    assign o_ctrl.decode  = (r_state == S_DEC);
    assign o_ctrl.execute = (r_state == S_EXE);
    assign o_ctrl.finish  = (r_state == S_POP);

endmodule

// ===== rtl/core/scca_datapath.sv =====
module scca_datapath #(
    parameter int PAGES_PER_CLASS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scca_pkg::t_ctrl                   i_ctrl,
    output scca_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [scca_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_cmd,
    input  logic [scca_pkg::SIZE_W-1:0]       i_req_size,
    input  logic [scca_pkg::ADDR_W-1:0]       i_chunk_address,
    output logic                              o_done,
    output logic [scca_pkg::ADDR_W-1:0]       o_result_address,
    output logic [scca_pkg::CLASS_W-1:0]      o_size_class,
    output logic [scca_pkg::STAT_W-1:0]       o_status
);

    localparam int NC     = scca_pkg::NUM_CLASSES;
    localparam int AW     = scca_pkg::ADDR_W;
    localparam int SW     = scca_pkg::SIZE_W;
    localparam int CW     = scca_pkg::CLASS_W;
    localparam int IDX_W  = $clog2(PAGES_PER_CLASS * scca_pkg::MAX_PAGE_CHUNKS);
    localparam int DEPTH  = PAGES_PER_CLASS * (2 * scca_pkg::MAX_PAGE_CHUNKS - 1);
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int PO_W   = $clog2(PAGES_PER_CLASS + 1);
    localparam int LEFT_W = $clog2(scca_pkg::MAX_PAGE_CHUNKS + 1);
    localparam int LIM_W  = (PO_W > scca_pkg::CFG_W) ? PO_W : scca_pkg::CFG_W;
    localparam int PG_W   = AW - scca_pkg::PAGE_SHIFT;

    logic                        r_cmd;
    logic [SW-1:0]               r_size;
    logic [AW-1:0]               r_addr;
    logic [CW-1:0]               r_cls;
    logic                        r_big;
    logic                        r_inrange;
    logic [scca_pkg::CFG_W-1:0]  r_page_limit;
    logic                        r_head_v   [NC];
    logic [IDX_W-1:0]            r_head_idx [NC];
    logic [PO_W-1:0]             r_po       [NC];
    logic [LEFT_W-1:0]           r_left     [NC];
    logic                        r_done;
    logic [AW-1:0]               r_res_addr;
    logic [CW-1:0]               r_res_cls;
    logic [scca_pkg::STAT_W-1:0] r_res_st;

    logic [SW-1:0]     n_eff;
    logic [CW-1:0]     n_alloc_cls;
    logic [CW-1:0]     n_free_cls;
    logic              head_v;
    logic [IDX_W-1:0]  head_idx;
    logic [PO_W-1:0]   po;
    logic [LEFT_W-1:0] left;
    logic [AW-1:0]     base_c;
    logic [SLOT_W-1:0] slot_base;
    logic [LIM_W-1:0]  lim_cfg;
    logic [LIM_W-1:0]  lim_eff;
    logic              pop;
    logic              exhausted;
    logic [PO_W-1:0]   pg;
    logic [LEFT_W-1:0] cpp;
    logic [LEFT_W-1:0] pl;
    logic [IDX_W-1:0]  aidx;
    logic [IDX_W-1:0]  sel_idx;
    logic [AW-1:0]     alloc_addr;
    logic [AW-1:0]     diff;
    logic              free_ok;
    logic [IDX_W-1:0]  fidx;
    logic [SLOT_W-1:0] slot;
    logic              ram_we;
    logic [IDX_W:0]    ram_rdata;

    always_comb begin
        n_eff       = (r_size == '0) ? SW'(1) : r_size;
        n_alloc_cls = '0;
        n_free_cls  = '0;
        for (int k = 0; k < NC - 1; k++) begin
            if ((SW'(16) << k) < n_eff) n_alloc_cls = n_alloc_cls + CW'(1);
        end
        for (int k = 1; k < NC; k++) begin
            if (r_addr >= scca_pkg::REGION_BASE[k]) n_free_cls = n_free_cls + CW'(1);
        end
    end

    always_comb begin
        slot_base = '0;
        base_c    = scca_pkg::REGION_BASE[0];
        for (int k = 0; k < NC; k++) begin
            if (r_cls == CW'(k)) begin
                slot_base = SLOT_W'(PAGES_PER_CLASS * (512 - (512 >> k)));
                base_c    = scca_pkg::REGION_BASE[k];
            end
        end
    end

    assign head_v   = r_head_v[r_cls];
    assign head_idx = r_head_idx[r_cls];
    assign po       = r_po[r_cls];
    assign left     = r_left[r_cls];

    assign lim_cfg   = LIM_W'(r_page_limit);
    assign lim_eff   = (lim_cfg < LIM_W'(PAGES_PER_CLASS)) ? lim_cfg : LIM_W'(PAGES_PER_CLASS);
    assign pop       = (r_cmd == scca_pkg::CMD_ALLOC) && !r_big && head_v;
    assign exhausted = (left == '0) && (LIM_W'(po) >= lim_eff);
    assign cpp       = LEFT_W'(scca_pkg::MAX_PAGE_CHUNKS) >> r_cls;
    assign pg        = (left == '0) ? po : po - PO_W'(1);
    assign pl        = (left == '0) ? cpp - LEFT_W'(1) : left - LEFT_W'(1);
    assign aidx      = (IDX_W'(pg) << (CW'(8) - r_cls)) | IDX_W'(pl);
    assign sel_idx   = pop ? head_idx : aidx;
    assign alloc_addr = base_c + (AW'(sel_idx) << (CW'(scca_pkg::MIN_SHIFT) + r_cls));

    assign diff    = r_addr - base_c;
    assign free_ok = r_inrange && (diff[AW-1:scca_pkg::PAGE_SHIFT] < PG_W'(po));
    assign fidx    = IDX_W'(diff >> (CW'(scca_pkg::MIN_SHIFT) + r_cls));

    assign slot   = slot_base + SLOT_W'(pop ? head_idx : fidx);
    assign ram_we = i_ctrl.execute && (r_cmd == scca_pkg::CMD_FREE) && free_ok;

    scca_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata ({head_v, head_idx}),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_size <= i_req_size;
            r_addr <= i_chunk_address;
        end
        if (i_ctrl.decode) begin
            if (r_cmd == scca_pkg::CMD_ALLOC) begin
                r_cls <= n_alloc_cls;
            end else begin
                r_cls <= n_free_cls;
            end
            r_big     <= (r_size > SW'(scca_pkg::PAGE_BYTES));
            r_inrange <= (r_addr >= scca_pkg::REGION_BASE[0]) && (r_addr < scca_pkg::REGION_TOP);
        end
        if (i_ctrl.execute) begin
            if (r_cmd == scca_pkg::CMD_ALLOC) begin
                if (r_big) begin
                    r_res_addr <= '0;
                    r_res_cls  <= '0;
                    r_res_st   <= scca_pkg::ST_TOO_LARGE;
                end else if (exhausted) begin
                    r_res_addr <= '0;
                    r_res_cls  <= r_cls;
                    r_res_st   <= scca_pkg::ST_NO_PAGES;
                end else begin
                    r_res_addr <= alloc_addr;
                    r_res_cls  <= r_cls;
                    r_res_st   <= scca_pkg::ST_OK;
                end
            end else begin
                r_res_addr <= '0;
                r_res_cls  <= free_ok ? r_cls : '0;
                r_res_st   <= free_ok ? scca_pkg::ST_OK : scca_pkg::ST_UNMANAGED;
                if (free_ok) r_head_idx[r_cls] <= fidx;
            end
        end
        if (i_ctrl.finish) begin
            r_head_idx[r_cls] <= ram_rdata[IDX_W-1:0];
            r_res_addr        <= alloc_addr;
            r_res_cls         <= r_cls;
            r_res_st          <= scca_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done       <= 1'b0;
            r_page_limit <= scca_pkg::CFG_W'(scca_pkg::LIMIT_RESET);
            for (int k = 0; k < NC; k++) begin
                r_head_v[k] <= 1'b0;
                r_po[k]     <= '0;
                r_left[k]   <= '0;
            end
        end else begin
            r_done <= (i_ctrl.execute && !pop) || i_ctrl.finish;
            if (i_cfg_we) r_page_limit <= i_cfg_wdata;
            if (i_ctrl.execute) begin
                if (r_cmd == scca_pkg::CMD_ALLOC) begin
                    if (!r_big && !head_v && !exhausted) begin
                        if (left == '0) r_po[r_cls] <= po + PO_W'(1);
                        r_left[r_cls] <= pl;
                    end
                end else if (free_ok) begin
                    r_head_v[r_cls] <= 1'b1;
                end
            end
            if (i_ctrl.finish) r_head_v[r_cls] <= ram_rdata[IDX_W];
        end
    end

    assign o_stat.pop       = pop;
    assign o_done           = r_done;
    assign o_result_address = r_res_addr;
    assign o_size_class     = r_res_cls;
    assign o_status         = r_res_st;

endmodule

// ===== rtl/core/size_class_chunk_allocator_unit.sv =====
// Power-of-two chunk allocator, nine classes of 16 to 4096 bytes. An item is
// taken when start is high and busy is low. o_done marks its result for one
// cycle; the item passes the decode and execute states, and o_done is
// registered from execute. An allocate popped from a free list passes a
// further pop state, because its link comes through the registered read of
// the link memory. The receiver cannot stall the result, so capture it in
// that cycle. busy falls at the edge that raises o_done, so a new item can be
// taken in the result cycle. The user must write page_limit through i_cfg_we
// and i_cfg_wdata only while busy is low; the block does not enforce this.
module size_class_chunk_allocator_unit #(
    parameter int PAGES_PER_CLASS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [scca_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [scca_pkg::ADDR_W-1:0]  i_chunk_address,
    input  logic                         i_cfg_we,
    input  logic [scca_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                         o_done,
    output logic [scca_pkg::ADDR_W-1:0]  o_result_address,
    output logic [scca_pkg::CLASS_W-1:0] o_size_class,
    output logic [scca_pkg::STAT_W-1:0]  o_status
);

    scca_pkg::t_ctrl ctrl;
    scca_pkg::t_stat stat;

    scca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    scca_datapath #(
        .PAGES_PER_CLASS (PAGES_PER_CLASS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cmd            (i_cmd),
        .i_req_size       (i_req_size),
        .i_chunk_address  (i_chunk_address),
        .o_done           (o_done),
        .o_result_address (o_result_address),
        .o_size_class     (o_size_class),
        .o_status         (o_status)
    );

endmodule

// ===== rtl/core/scca_checker.sv =====
module scca_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [scca_pkg::ADDR_W-1:0]  o_result_address,
    input logic [scca_pkg::CLASS_W-1:0] o_size_class,
    input logic [scca_pkg::STAT_W-1:0]  o_status
);

    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != scca_pkg::ST_OK)) |-> (o_result_address == '0))
        else $error("error result carries an address");

    a_big_class_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_status == scca_pkg::ST_TOO_LARGE) ||
                    (o_status == scca_pkg::ST_UNMANAGED))) |-> (o_size_class == '0))
        else $error("rejected item reports a class");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted item did not hold busy");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_size_class < scca_pkg::CLASS_W'(scca_pkg::NUM_CLASSES)))
        else $error("class index out of range");

endmodule

bind size_class_chunk_allocator_unit scca_checker u_scca_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_result_address (o_result_address),
    .o_size_class     (o_size_class),
    .o_status         (o_status)
);

// ===== tb/sv/scca_checker.sv =====
`timescale 1ns / 1ps

module scca_scoreboard
    import scca_pkg::*;
#(
    parameter int PAGES_PER_CLASS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                i_cmd,
    input  logic [SIZE_W-1:0]   i_req_size,
    input  logic [ADDR_W-1:0]   i_chunk_address,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                o_done,
    input  logic [ADDR_W-1:0]   o_result_address,
    input  logic [CLASS_W-1:0]  o_size_class,
    input  logic [STAT_W-1:0]   o_status,
    output int                  fail_count,
    output int                  pending_count
);

    localparam int TOTAL_CHUNKS = PAGES_PER_CLASS * 511;

    typedef struct {
        t_addr              addr;
        logic [CLASS_W-1:0] cls;
        logic [STAT_W-1:0]  st;
    } t_chunk_reply;

    t_chunk_reply expected_replies[$];

    logic head_valid [NUM_CLASSES];
    int   head_index [NUM_CLASSES];
    logic link_valid [TOTAL_CHUNKS];
    int   link_index [TOTAL_CHUNKS];
    int   pages_opened [NUM_CLASSES];
    int   chunks_left [NUM_CLASSES];
    int   page_limit;

    assign pending_count = expected_replies.size();

    function automatic int link_slot(int c, int idx);
        int s;
        s = PAGES_PER_CLASS * (512 - (512 >> c)) + idx;
        return (s < TOTAL_CHUNKS) ? s : 0;
    endfunction

    function automatic t_chunk_reply allocate_chunk(logic [SIZE_W-1:0] req);
        t_chunk_reply r;
        logic [32:0]  n;
        int           c;
        int           idx;
        int           per_page;
        int           limit;
        r.addr = '0;
        r.cls  = '0;
        r.st   = ST_OK;
        n = (req == 0) ? 33'd1 : {1'b0, req};
        if (n > PAGE_BYTES) begin
            r.st = ST_TOO_LARGE;
            return r;
        end
        c = 0;
        while (c < NUM_CLASSES - 1 && (33'd16 << c) < n)
            c++;
        per_page = 256 >> c;
        r.cls = c[CLASS_W-1:0];
        if (head_valid[c]) begin
            idx = head_index[c];
            head_valid[c] = link_valid[link_slot(c, idx)];
            head_index[c] = link_index[link_slot(c, idx)];
        end else begin
            if (chunks_left[c] == 0) begin
                limit = (page_limit < PAGES_PER_CLASS) ? page_limit : PAGES_PER_CLASS;
                if (pages_opened[c] >= limit) begin
                    r.st = ST_NO_PAGES;
                    return r;
                end
                pages_opened[c]++;
                chunks_left[c] = per_page;
            end
            chunks_left[c]--;
            idx = (pages_opened[c] - 1) * per_page + chunks_left[c];
        end
        r.addr = REGION_BASE[c] + (t_addr'(idx) << (MIN_SHIFT + c));
        return r;
    endfunction

    function automatic t_chunk_reply reclaim_chunk(t_addr a);
        t_chunk_reply r;
        int           c;
        t_addr        off;
        r.addr = '0;
        r.cls  = '0;
        r.st   = ST_UNMANAGED;
        if (a < REGION_BASE[0] || a >= REGION_TOP)
            return r;
        c = NUM_CLASSES - 1;
        while (c > 0 && a < REGION_BASE[c])
            c--;
        off = (a - REGION_BASE[c]) >> (MIN_SHIFT + c);
        if (off >= t_addr'(pages_opened[c] * (256 >> c)))
            return r;
        link_valid[link_slot(c, int'(off))] = head_valid[c];
        link_index[link_slot(c, int'(off))] = head_index[c];
        head_valid[c] = 1'b1;
        head_index[c] = int'(off);
        r.cls = c[CLASS_W-1:0];
        r.st  = ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_chunk_reply want;
        if (!i_rst_n) begin
            page_limit <= LIMIT_RESET;
            fail_count <= 0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_valid[c]   = 1'b0;
                head_index[c]   = 0;
                pages_opened[c] = 0;
                chunks_left[c]  = 0;
            end
            expected_replies.delete();
        end else begin
            if (i_cfg_we)
                page_limit <= int'(i_cfg_wdata);
            if (o_done) begin
                if (expected_replies.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: result with nothing expected: addr=%h cls=%0d st=%0d",
                                 o_result_address, o_size_class, o_status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_replies.pop_front();
                    if (want.addr !== o_result_address || want.cls !== o_size_class ||
                        want.st !== o_status) begin
                        if (fail_count < 10)
                            $display("ERROR: exp addr=%h cls=%0d st=%0d, got addr=%h cls=%0d st=%0d",
                                     want.addr, want.cls, want.st,
                                     o_result_address, o_size_class, o_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                if (i_cmd == CMD_ALLOC)
                    expected_replies.push_back(allocate_chunk(i_req_size));
                else
                    expected_replies.push_back(reclaim_chunk(i_chunk_address));
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import scca_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cmd = CMD_ALLOC;
    logic [SIZE_W-1:0]   i_req_size = '0;
    logic [ADDR_W-1:0]   i_chunk_address = '0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;
    logic                o_done;
    logic [ADDR_W-1:0]   o_result_address;
    logic [CLASS_W-1:0]  o_size_class;
    logic [STAT_W-1:0]   o_status;
    int                  fail_count;
    int                  pending_count;
    int                  cycle_count = 0;
    logic                steady = 1'b0;
    t_addr               live_chunks[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    size_class_chunk_allocator_unit #(.PAGES_PER_CLASS(16)) uut (.*);

    scca_scoreboard #(.PAGES_PER_CLASS(16)) u_checker (.*);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
        if (o_done && o_status == ST_OK && o_result_address != 0)
            live_chunks.push_back(o_result_address);
    end

    task automatic send_item(logic cmd, logic [SIZE_W-1:0] req, t_addr addr);
        logic taken;
        if (!steady && $urandom_range(99) < 27) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_req_size      <= req;
        i_chunk_address <= addr;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] class_size(int c);
        int hi;
        int lo;
        hi = 16 << c;
        lo = (c == 0) ? 0 : (8 << c) + 1;
        return SIZE_W'($urandom_range(hi, lo));
    endfunction

    task automatic random_item();
        int    k;
        int    pick;
        t_addr a;
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_item(CMD_ALLOC, class_size($urandom_range(NUM_CLASSES - 1)), '0);
        end else if (pick < 56) begin
            send_item(CMD_ALLOC, $urandom(), '0);
        end else if (pick < 88 && live_chunks.size() != 0) begin
            k = $urandom_range(live_chunks.size() - 1);
            a = live_chunks[k];
            if ($urandom_range(99) < 95)
                live_chunks.delete(k);
            if ($urandom_range(99) < 20)
                a = a | t_addr'($urandom_range(15));
            send_item(CMD_FREE, '0, a);
        end else if (pick < 95) begin
            k = $urandom_range(NUM_CLASSES - 1);
            a = REGION_BASE[k] + t_addr'($urandom_range(20 * PAGE_BYTES));
            send_item(CMD_FREE, '0, a);
        end else begin
            a = t_addr'({$urandom(), $urandom()});
            send_item(CMD_FREE, $urandom(), a);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] limits[5] = '{5'd1, 5'd31, 5'd0, 5'd3, 5'd16};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(CMD_ALLOC, 32'd0, '0);
        send_item(CMD_ALLOC, 32'd1, '0);
        send_item(CMD_ALLOC, 32'd16, '0);
        send_item(CMD_ALLOC, 32'd17, '0);
        for (int c = 2; c < NUM_CLASSES; c++)
            send_item(CMD_ALLOC, SIZE_W'(16 << c), '0);
        send_item(CMD_ALLOC, 32'd4097, '0);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF, '0);
        send_item(CMD_FREE, '0, REGION_BASE[0] + 48'h0FF7);
        send_item(CMD_FREE, '0, REGION_BASE[0] + 48'h0FF0);
        send_item(CMD_ALLOC, 32'd9, '0);
        send_item(CMD_FREE, '0, REGION_BASE[8]);
        send_item(CMD_FREE, '0, REGION_BASE[8]);
        send_item(CMD_ALLOC, 32'd4096, '0);
        send_item(CMD_ALLOC, 32'd4000, '0);
        send_item(CMD_FREE, '0, '0);
        send_item(CMD_FREE, '0, 48'hFFFF_FFFF_FFFF);
        send_item(CMD_FREE, '0, REGION_TOP);
        send_item(CMD_FREE, '0, REGION_BASE[0] - 48'd1);
        send_item(CMD_FREE, '0, REGION_BASE[3] + 48'h5000);

        foreach (limits[p]) begin
            write_limit(limits[p]);
            for (int i = 0; i < 140; i++) begin
                steady <= (p == 1 && i >= 20 && i < 100);
                random_item();
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
